// ===== design/geu_pkg.sv =====
// Shared types, constants and codes for the Gaussian elimination unit.
`default_nettype none

package geu_pkg;

    // Default largest matrix dimension
    localparam int MAX_DIM_DEF = 8;

    // Size register
    localparam int        SIZE_W   = 4;
    localparam logic [SIZE_W-1:0] SIZE_RST = 4'd8;

    // Single-precision constants
    localparam int          DATA_W  = 32;
    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_DNAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QBIT = 32'h0040_0000;

    // Restoring division produces this many quotient bits
    localparam int DIV_STEPS = 26;

    // Floating-point unit operations
    typedef enum logic [1:0] {
        FOP_MUL,
        FOP_SUB,
        FOP_DIV
    } t_fp_op;

    // Memory write data source
    typedef enum logic [1:0] {
        WS_IN,
        WS_FPU,
        WS_ONE,
        WS_ZERO
    } t_wsel;

    // Controller states
    typedef enum logic [4:0] {
        S_LOAD,
        S_PIV_RD,
        S_PIV_LD,
        S_DIV_RD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ONE_WR,
        S_FAC_RD,
        S_FAC_LD,
        S_MUL_RD,
        S_MUL_GO,
        S_MUL_WAIT,
        S_SUB_GO,
        S_SUB_WAIT,
        S_ZERO_WR,
        S_OUT_RD,
        S_OUT_LD
    } t_ctl_state;

    // Floating-point unit states
    typedef enum logic [3:0] {
        F_IDLE,
        F_NORMA,
        F_NORMB,
        F_EXEC,
        F_DIV,
        F_DIVEND,
        F_NORM,
        F_ROUND,
        F_DONE
    } t_fpu_state;

    // Controller to datapath commands
    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        t_wsel  wsel;
        logic   ld_piv;
        logic   ld_prod;
        logic   fpu_start;
        t_fp_op fpu_op;
        logic   out_ld;
        logic   out_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fpu_done;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/geu_fpu.sv =====
// Shared multi-cycle single-precision multiply, subtract and divide unit.
`default_nettype none

module geu_fpu (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire geu_pkg::t_fp_op i_op,
    input  wire logic [31:0]     i_a,
    input  wire logic [31:0]     i_b,
    output logic                 o_done,
    output logic [31:0]          o_res
);

    geu_pkg::t_fpu_state r_state, n_state;
    geu_pkg::t_fp_op     r_op, n_op;
    logic                r_sa, n_sa, r_sb, n_sb, r_sgn, n_sgn, r_sticky, n_sticky;
    logic signed [9:0]   r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [23:0]         r_ma, n_ma, r_mb, n_mb;
    logic [26:0]         r_m, n_m;
    logic [24:0]         r_rem, n_rem;
    logic [25:0]         r_q, n_q;
    logic [4:0]          r_cnt, n_cnt;
    logic [31:0]         r_res, n_res;

    // Operand decode
    logic [7:0]        a_exp, b_exp;
    logic              a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, b_sgn, x_sgn;
    logic              spec;
    logic [31:0]       spec_res;
    logic signed [9:0] a_e, b_e;

    always_comb begin
        a_exp  = i_a[30:23];
        b_exp  = i_b[30:23];
        a_nan  = (&a_exp) && (|i_a[22:0]);
        a_inf  = (&a_exp) && !(|i_a[22:0]);
        a_zero = (a_exp == 8'd0) && !(|i_a[22:0]);
        b_nan  = (&b_exp) && (|i_b[22:0]);
        b_inf  = (&b_exp) && !(|i_b[22:0]);
        b_zero = (b_exp == 8'd0) && !(|i_b[22:0]);
        b_sgn  = (i_op == geu_pkg::FOP_SUB) ? ~i_b[31] : i_b[31];
        x_sgn  = i_a[31] ^ i_b[31];
        a_e    = (a_exp == 8'd0) ? -10'sd126 : $signed({2'b00, a_exp}) - 10'sd127;
        b_e    = (b_exp == 8'd0) ? -10'sd126 : $signed({2'b00, b_exp}) - 10'sd127;
        spec     = 1'b1;
        spec_res = geu_pkg::FP_DNAN;
        priority if (a_nan) begin
            spec_res = i_a | geu_pkg::FP_QBIT;
        end else if (b_nan) begin
            spec_res = i_b | geu_pkg::FP_QBIT;
        end else begin
            unique case (i_op)
                geu_pkg::FOP_MUL: begin
                    priority if ((a_inf || b_inf) && (a_zero || b_zero)) begin
                        spec_res = geu_pkg::FP_DNAN;
                    end else if (a_inf || b_inf) begin
                        spec_res = {x_sgn, 8'hFF, 23'd0};
                    end else if (a_zero || b_zero) begin
                        spec_res = {x_sgn, 31'd0};
                    end else begin
                        spec = 1'b0;
                    end
                end
                geu_pkg::FOP_DIV: begin
                    priority if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                        spec_res = geu_pkg::FP_DNAN;
                    end else if (a_inf || b_zero) begin
                        spec_res = {x_sgn, 8'hFF, 23'd0};
                    end else if (a_zero || b_inf) begin
                        spec_res = {x_sgn, 31'd0};
                    end else begin
                        spec = 1'b0;
                    end
                end
                geu_pkg::FOP_SUB: begin
                    priority if (a_inf && b_inf && (i_a[31] != b_sgn)) begin
                        spec_res = geu_pkg::FP_DNAN;
                    end else if (a_inf) begin
                        spec_res = i_a;
                    end else if (b_inf) begin
                        spec_res = {b_sgn, 8'hFF, 23'd0};
                    end else if (a_zero && b_zero) begin
                        spec_res = {i_a[31] & b_sgn, 31'd0};
                    end else if (a_zero) begin
                        spec_res = {b_sgn, i_b[30:0]};
                    end else if (b_zero) begin
                        spec_res = i_a;
                    end else begin
                        spec = 1'b0;
                    end
                end
                default: begin
                    spec = 1'b0;
                end
            endcase
        end
    end

    // Align and add for subtraction
    logic              a_big, s_sgn;
    logic signed [9:0] e_l, e_s, e_d;
    logic [23:0]       m_l, m_s;
    logic [4:0]        d_c;
    logic [26:0]       ext, shv, smask, bsh;
    logic [27:0]       ssum;

    always_comb begin
        a_big = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
        e_l   = a_big ? r_ea : r_eb;
        e_s   = a_big ? r_eb : r_ea;
        m_l   = a_big ? r_ma : r_mb;
        m_s   = a_big ? r_mb : r_ma;
        s_sgn = a_big ? r_sa : r_sb;
        e_d   = e_l - e_s;
        d_c   = (e_d > 10'sd27) ? 5'd27 : e_d[4:0];
        ext   = {m_s, 3'b000};
        shv   = ext >> d_c;
        smask = (27'd1 << d_c) - 27'd1;
        bsh   = {shv[26:1], shv[0] | (|(ext & smask))};
        if (r_sa == r_sb) begin
            ssum = {1'b0, m_l, 3'b000} + {1'b0, bsh};
        end else begin
            ssum = {1'b0, m_l, 3'b000} - {1'b0, bsh};
        end
    end

    // Product of normalized significands
    logic [47:0] prod;
    assign prod = r_ma * r_mb;

    // Restoring division step
    logic        div_ge;
    logic [24:0] rem_sub;
    always_comb begin
        div_ge  = r_rem >= {1'b0, r_mb};
        rem_sub = div_ge ? (r_rem - {1'b0, r_mb}) : r_rem;
    end

    // Round to nearest even and pack
    logic signed [9:0] be, sh;
    logic [4:0]        sh_c;
    logic [26:0]       rshv;
    logic [30:0]       base;
    logic              r_lsb, r_g, r_rest, r_inc, ovf;
    logic [31:0]       rnd_res;

    always_comb begin
        be     = r_e + 10'sd127;
        sh     = 10'sd1 - be;
        sh_c   = (sh > 10'sd27) ? 5'd27 : sh[4:0];
        rshv   = r_m >> sh_c;
        ovf    = be >= 10'sd255;
        if (be >= 10'sd1) begin
            base   = {be[7:0], r_m[25:3]};
            r_lsb  = r_m[3];
            r_g    = r_m[2];
            r_rest = (|r_m[1:0]) | r_sticky;
        end else begin
            base   = {8'd0, rshv[25:3]};
            r_lsb  = rshv[3];
            r_g    = rshv[2];
            r_rest = (|rshv[1:0]) | r_sticky | (|(r_m & ((27'd1 << sh_c) - 27'd1)));
        end
        r_inc = r_g & (r_rest | r_lsb);
        if (ovf) begin
            rnd_res = {r_sgn, 8'hFF, 23'd0};
        end else begin
            rnd_res = {r_sgn, base + {30'd0, r_inc}};
        end
    end

    // Next state and working registers
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_sgn    = r_sgn;
        n_sticky = r_sticky;
        n_ea     = r_ea;
        n_eb     = r_eb;
        n_e      = r_e;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_m      = r_m;
        n_rem    = r_rem;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_res    = r_res;
        unique case (r_state)
            geu_pkg::F_IDLE: begin
                if (i_start) begin
                    n_op  = i_op;
                    n_sa  = i_a[31];
                    n_sb  = b_sgn;
                    n_sgn = x_sgn;
                    n_ea  = a_e;
                    n_eb  = b_e;
                    n_ma  = {a_exp != 8'd0, i_a[22:0]};
                    n_mb  = {b_exp != 8'd0, i_b[22:0]};
                    n_res = spec_res;
                    n_state = spec ? geu_pkg::F_DONE : geu_pkg::F_NORMA;
                end
            end
            // Normalize subnormal operands one bit a cycle
            geu_pkg::F_NORMA: begin
                if (r_ma[23]) begin
                    n_state = geu_pkg::F_NORMB;
                end else begin
                    n_ma = {r_ma[22:0], 1'b0};
                    n_ea = r_ea - 10'sd1;
                end
            end
            geu_pkg::F_NORMB: begin
                if (r_mb[23]) begin
                    n_state = geu_pkg::F_EXEC;
                end else begin
                    n_mb = {r_mb[22:0], 1'b0};
                    n_eb = r_eb - 10'sd1;
                end
            end
            geu_pkg::F_EXEC: begin
                unique case (r_op)
                    geu_pkg::FOP_MUL: begin
                        if (prod[47]) begin
                            n_m      = prod[47:21];
                            n_sticky = |prod[20:0];
                            n_e      = r_ea + r_eb + 10'sd1;
                        end else begin
                            n_m      = prod[46:20];
                            n_sticky = |prod[19:0];
                            n_e      = r_ea + r_eb;
                        end
                        n_state = geu_pkg::F_ROUND;
                    end
                    geu_pkg::FOP_DIV: begin
                        n_rem   = {1'b0, r_ma};
                        n_q     = '0;
                        n_cnt   = '0;
                        n_e     = r_ea - r_eb;
                        n_state = geu_pkg::F_DIV;
                    end
                    default: begin
                        n_sgn = s_sgn;
                        if (ssum == 28'd0) begin
                            n_res   = geu_pkg::FP_ZERO;
                            n_state = geu_pkg::F_DONE;
                        end else if (ssum[27]) begin
                            n_m      = ssum[27:1];
                            n_sticky = ssum[0];
                            n_e      = e_l + 10'sd1;
                            n_state  = geu_pkg::F_NORM;
                        end else begin
                            n_m      = ssum[26:0];
                            n_sticky = 1'b0;
                            n_e      = e_l;
                            n_state  = geu_pkg::F_NORM;
                        end
                    end
                endcase
            end
            // One quotient bit a cycle
            geu_pkg::F_DIV: begin
                n_q   = {r_q[24:0], div_ge};
                n_rem = {rem_sub[23:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(geu_pkg::DIV_STEPS - 1)) begin
                    n_state = geu_pkg::F_DIVEND;
                end
            end
            geu_pkg::F_DIVEND: begin
                n_sticky = |r_rem;
                if (r_q[25]) begin
                    n_m = {r_q, 1'b0};
                end else begin
                    n_m = {r_q[24:0], 2'b00};
                    n_e = r_e - 10'sd1;
                end
                n_state = geu_pkg::F_ROUND;
            end
            // Shift left after cancellation
            geu_pkg::F_NORM: begin
                if (r_m[26]) begin
                    n_state = geu_pkg::F_ROUND;
                end else begin
                    n_m = {r_m[25:0], 1'b0};
                    n_e = r_e - 10'sd1;
                end
            end
            geu_pkg::F_ROUND: begin
                n_res   = rnd_res;
                n_state = geu_pkg::F_DONE;
            end
            geu_pkg::F_DONE: begin
                n_state = geu_pkg::F_IDLE;
            end
            default: begin
                n_state = geu_pkg::F_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= geu_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_sgn    <= n_sgn;
        r_sticky <= n_sticky;
        r_ea     <= n_ea;
        r_eb     <= n_eb;
        r_e      <= n_e;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_m      <= n_m;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
    end

    assign o_done = (r_state == geu_pkg::F_DONE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== design/geu_dp.sv =====
// Datapath: matrix memory, operand registers, shared FP unit and output register.
`default_nettype none

module geu_dp #(
    parameter int MAX_DIM = geu_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire geu_pkg::t_dp_cmd            i_cmd,
    input  wire logic [$clog2(MAX_DIM)-1:0]  i_row,
    input  wire logic [$clog2(MAX_DIM)-1:0]  i_col,
    input  wire logic [31:0]                 i_element_bits,
    output geu_pkg::t_dp_stat                o_stat,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [31:0]                      o_result_bits,
    output logic                             o_last_element
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rdata, r_piv, r_prod, r_obits;
    logic          r_ovalid, r_olast;
    logic [AW-1:0] addr;
    logic [31:0]   wdata, fpu_a, fpu_b, fpu_res;
    logic          fpu_done;

    // Element (row, col) sits at row * MAX_DIM + col
    assign addr = AW'(i_row) * AW'(MAX_DIM) + AW'(i_col);

    // Write data select
    always_comb begin
        unique case (i_cmd.wsel)
            geu_pkg::WS_IN:   wdata = i_element_bits;
            geu_pkg::WS_FPU:  wdata = fpu_res;
            geu_pkg::WS_ONE:  wdata = geu_pkg::FP_ONE;
            geu_pkg::WS_ZERO: wdata = geu_pkg::FP_ZERO;
            default:          wdata = geu_pkg::FP_ZERO;
        endcase
    end

    // Matrix memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    // Pivot or row factor, and the latest product
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_piv) begin
            r_piv <= r_rdata;
        end
        if (i_cmd.ld_prod) begin
            r_prod <= fpu_res;
        end
    end

    // Operand routing per operation
    always_comb begin
        unique case (i_cmd.fpu_op)
            geu_pkg::FOP_DIV: begin
                fpu_a = r_rdata;
                fpu_b = r_piv;
            end
            geu_pkg::FOP_SUB: begin
                fpu_a = r_rdata;
                fpu_b = r_prod;
            end
            default: begin
                fpu_a = r_piv;
                fpu_b = r_rdata;
            end
        endcase
    end

    geu_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.fpu_start),
        .i_op    (i_cmd.fpu_op),
        .i_a     (fpu_a),
        .i_b     (fpu_b),
        .o_done  (fpu_done),
        .o_res   (fpu_res)
    );

    // Output register: load on command, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_obits <= r_rdata;
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_stat.fpu_done = fpu_done;
    assign o_stat.out_busy = r_ovalid;
    assign o_valid         = r_ovalid;
    assign o_result_bits   = r_obits;
    assign o_last_element  = r_olast;

endmodule

`default_nettype wire

// ===== design/geu_ctrl.sv =====
// Controller: load, elimination sequencing and emission state machine.
`default_nettype none

module geu_ctrl #(
    parameter int MAX_DIM = geu_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [geu_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire geu_pkg::t_dp_stat           i_stat,
    output geu_pkg::t_dp_cmd                 o_cmd,
    output logic [$clog2(MAX_DIM)-1:0]       o_row,
    output logic [$clog2(MAX_DIM)-1:0]       o_col
);

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int IW = $clog2(MAX_DIM);

    geu_pkg::t_ctl_state         r_state, n_state;
    logic [geu_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [CW-1:0]               r_k, n_k, r_i, n_i, r_j, n_j, r_row, n_row, r_col, n_col;
    logic [CW-1:0]               dim, dim_m1, a_row, a_col;
    logic                        in_xfer, cnt_last;

    // Size in use, clamped to 1..MAX_DIM
    always_comb begin
        if (r_size == '0) begin
            dim = CW'(1);
        end else if (int'(r_size) > MAX_DIM) begin
            dim = CW'(MAX_DIM);
        end else begin
            dim = CW'(r_size);
        end
        dim_m1 = dim - CW'(1);
    end

    assign o_stall  = (r_state != geu_pkg::S_LOAD);
    assign in_xfer  = i_valid && !o_stall;
    assign cnt_last = (r_row == dim_m1) && (r_col == dim_m1);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_row   = r_row;
        n_col   = r_col;
        o_cmd   = '0;
        a_row   = r_row;
        a_col   = r_col;
        unique case (r_state)
            geu_pkg::S_LOAD: begin
                if (in_xfer) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.wsel  = geu_pkg::WS_IN;
                    if (cnt_last) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_k     = '0;
                        n_state = geu_pkg::S_PIV_RD;
                    end else if (r_col == dim_m1) begin
                        n_col = '0;
                        n_row = r_row + CW'(1);
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            geu_pkg::S_PIV_RD: begin
                o_cmd.rd_en = 1'b1;
                a_row       = r_k;
                a_col       = r_k;
                n_state     = geu_pkg::S_PIV_LD;
            end
            geu_pkg::S_PIV_LD: begin
                o_cmd.ld_piv = 1'b1;
                n_j          = r_k + CW'(1);
                n_state      = (r_k + CW'(1) < dim) ? geu_pkg::S_DIV_RD : geu_pkg::S_ONE_WR;
            end
            geu_pkg::S_DIV_RD: begin
                o_cmd.rd_en = 1'b1;
                a_row       = r_k;
                a_col       = r_j;
                n_state     = geu_pkg::S_DIV_GO;
            end
            geu_pkg::S_DIV_GO: begin
                o_cmd.fpu_start = 1'b1;
                o_cmd.fpu_op    = geu_pkg::FOP_DIV;
                n_state         = geu_pkg::S_DIV_WAIT;
            end
            geu_pkg::S_DIV_WAIT: begin
                a_row = r_k;
                a_col = r_j;
                if (i_stat.fpu_done) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.wsel  = geu_pkg::WS_FPU;
                    n_j         = r_j + CW'(1);
                    n_state     = (r_j + CW'(1) < dim) ? geu_pkg::S_DIV_RD
                                                        : geu_pkg::S_ONE_WR;
                end
            end
            geu_pkg::S_ONE_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wsel  = geu_pkg::WS_ONE;
                a_row       = r_k;
                a_col       = r_k;
                n_i         = r_k + CW'(1);
                n_state     = (r_k + CW'(1) < dim) ? geu_pkg::S_FAC_RD : geu_pkg::S_OUT_RD;
            end
            geu_pkg::S_FAC_RD: begin
                o_cmd.rd_en = 1'b1;
                a_row       = r_i;
                a_col       = r_k;
                n_state     = geu_pkg::S_FAC_LD;
            end
            geu_pkg::S_FAC_LD: begin
                o_cmd.ld_piv = 1'b1;
                n_j          = r_k + CW'(1);
                n_state      = geu_pkg::S_MUL_RD;
            end
            geu_pkg::S_MUL_RD: begin
                o_cmd.rd_en = 1'b1;
                a_row       = r_k;
                a_col       = r_j;
                n_state     = geu_pkg::S_MUL_GO;
            end
            geu_pkg::S_MUL_GO: begin
                o_cmd.fpu_start = 1'b1;
                o_cmd.fpu_op    = geu_pkg::FOP_MUL;
                n_state         = geu_pkg::S_MUL_WAIT;
            end
            // Hold the product and fetch the element it updates
            geu_pkg::S_MUL_WAIT: begin
                a_row = r_i;
                a_col = r_j;
                if (i_stat.fpu_done) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.ld_prod = 1'b1;
                    n_state       = geu_pkg::S_SUB_GO;
                end
            end
            geu_pkg::S_SUB_GO: begin
                o_cmd.fpu_start = 1'b1;
                o_cmd.fpu_op    = geu_pkg::FOP_SUB;
                n_state         = geu_pkg::S_SUB_WAIT;
            end
            geu_pkg::S_SUB_WAIT: begin
                a_row = r_i;
                a_col = r_j;
                if (i_stat.fpu_done) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.wsel  = geu_pkg::WS_FPU;
                    n_j         = r_j + CW'(1);
                    n_state     = (r_j + CW'(1) < dim) ? geu_pkg::S_MUL_RD
                                                        : geu_pkg::S_ZERO_WR;
                end
            end
            geu_pkg::S_ZERO_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wsel  = geu_pkg::WS_ZERO;
                a_row       = r_i;
                a_col       = r_k;
                if (r_i + CW'(1) < dim) begin
                    n_i     = r_i + CW'(1);
                    n_state = geu_pkg::S_FAC_RD;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = geu_pkg::S_PIV_RD;
                end
            end
            // Emit row-major once the output slot is free
            geu_pkg::S_OUT_RD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = geu_pkg::S_OUT_LD;
                end
            end
            geu_pkg::S_OUT_LD: begin
                o_cmd.out_ld   = 1'b1;
                o_cmd.out_last = cnt_last;
                if (cnt_last) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_state = geu_pkg::S_LOAD;
                end else begin
                    n_state = geu_pkg::S_OUT_RD;
                    if (r_col == dim_m1) begin
                        n_col = '0;
                        n_row = r_row + CW'(1);
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            default: begin
                n_state = geu_pkg::S_LOAD;
            end
        endcase
        // Size write abandons a partial load
        if (i_cfg_wr_en) begin
            n_size = i_cfg_wr_data;
            n_row  = '0;
            n_col  = '0;
        end
    end

    assign o_row = a_row[IW-1:0];
    assign o_col = a_col[IW-1:0];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= geu_pkg::S_LOAD;
            r_size  <= geu_pkg::SIZE_RST;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

`ifndef NO_ASSERTIONS
    // FPU results arrive only while a wait state expects them
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.fpu_done |-> (r_state == geu_pkg::S_DIV_WAIT ||
                             r_state == geu_pkg::S_MUL_WAIT ||
                             r_state == geu_pkg::S_SUB_WAIT))
        else $error("fpu result with no operation pending");

    // Never overwrite an output that has not been transferred
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> !i_stat.out_busy)
        else $error("output register overwritten");

    // Completing the load starts elimination
    a_load_to_elim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && cnt_last && !i_cfg_wr_en) |=> (r_state == geu_pkg::S_PIV_RD))
        else $error("elimination did not start after the last element");
`endif

endmodule

`default_nettype wire

// ===== design/gaussian_elimination_unit_upper.sv =====
// Top level: unit upper-triangular Gaussian elimination of a single-precision matrix.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  input    | i_valid / o_stall         | i_element_bits
//  output   | o_valid / i_stall         | o_result_bits, o_last_element
//  config   | i_cfg_wr_en               | i_cfg_wr_data (matrix size)
//
// Loading writes each accepted element into the matrix memory. Elimination runs on
// one shared multi-cycle FP unit, which normalizes subnormal operands and then
// multiplies, subtracts with post-normalization, or divides by restoring division,
// and rounds to nearest even; special operands skip straight to the result.
// Emission reads the next element only once the output register has been emptied.
// Reset is synchronous active low; the size returns to 8. Input is stalled
// from the last loaded element until the last result is in the output register.
`default_nettype none

module gaussian_elimination_unit_upper #(
    parameter int MAX_DIM = geu_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [geu_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [31:0]                 i_element_bits,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [31:0]                      o_result_bits,
    output logic                             o_last_element
);

    geu_pkg::t_dp_cmd               cmd;
    geu_pkg::t_dp_stat              stat;
    logic [$clog2(MAX_DIM)-1:0]     row, col;

    geu_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_row         (row),
        .o_col         (col)
    );

    geu_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_row          (row),
        .i_col          (col),
        .i_element_bits (i_element_bits),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_bits  (o_result_bits),
        .o_last_element (o_last_element)
    );

endmodule

`default_nettype wire

// ===== verif/geu_checker.sv =====
// Checker for the Gaussian elimination unit: predicts reduced matrices and compares results.
`timescale 1ns / 100ps

module geu_checker #(
    parameter int MAX_DIM = geu_pkg::MAX_DIM_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [geu_pkg::SIZE_W-1:0] i_cfg_wr_data,
    input  wire logic                       i_valid,
    input  wire logic                       i_in_stall,
    input  wire logic [31:0]                i_element_bits,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [31:0]                i_result_bits,
    input  wire logic                       i_last_element,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked
);

    typedef struct packed {
        logic [31:0] bits;
        logic        last;
    } t_elem_exp;

    t_elem_exp                  exp_elems[$];
    logic [31:0]                shadow_mtx[MAX_DIM*MAX_DIM];
    logic [geu_pkg::SIZE_W-1:0] size_reg;
    int                         fill_cnt;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_errors++;
    endtask

    function automatic bit is_nan(input logic [31:0] b);
        return b[30:23] == 8'hFF && b[22:0] != 0;
    endfunction

    function automatic bit is_inf(input logic [31:0] b);
        return b[30:23] == 8'hFF && b[22:0] == 0;
    endfunction

    function automatic bit is_zero(input logic [31:0] b);
        return b[30:0] == 0;
    endfunction

    // Exact widening of a single to a double
    function automatic real sgl_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 0) begin
            r = real'(b[22:0]) * (2.0 ** -149);
            if (b[31])
                r = (b[22:0] == 0) ? $bitstoreal(64'h8000_0000_0000_0000) : -r;
        end else begin
            r = $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'b0});
        end
        return r;
    endfunction

    // Round a double to single, nearest-even, subnormals kept
    function automatic logic [31:0] real_to_sgl(input real r);
        logic [63:0] d;
        logic [63:0] mant;
        logic [63:0] q;
        logic        rb;
        logic        sticky;
        int          ex;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 0)
            return {d[63], 31'b0};
        ex = int'(d[62:52]) - 1023;
        if (ex > 127)
            return {d[63], 8'hFF, 23'b0};
        mant = {11'b1, d[51:0]};
        sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
        if (sh > 60)
            return {d[63], 31'b0};
        q = mant >> sh;
        rb = mant[sh-1];
        sticky = (mant & ((64'd1 << (sh - 1)) - 1)) != 0;
        if (rb && (sticky || q[0]))
            q = q + 1;
        if (ex >= -126) begin
            if (q[24]) begin
                q = q >> 1;
                ex++;
            end
            if (ex > 127)
                return {d[63], 8'hFF, 23'b0};
            return {d[63], 8'(ex + 127), q[22:0]};
        end
        return {d[63], q[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a)) return a | geu_pkg::FP_QBIT;
        if (is_nan(b)) return b | geu_pkg::FP_QBIT;
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return geu_pkg::FP_DNAN;
        if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'b0};
        return real_to_sgl(sgl_to_real(a) * sgl_to_real(b));
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a)) return a | geu_pkg::FP_QBIT;
        if (is_nan(b)) return b | geu_pkg::FP_QBIT;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? geu_pkg::FP_DNAN : a;
        if (is_inf(a)) return a;
        if (is_inf(b)) return {~b[31], b[30:0]};
        return real_to_sgl(sgl_to_real(a) - sgl_to_real(b));
    endfunction

    function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a)) return a | geu_pkg::FP_QBIT;
        if (is_nan(b)) return b | geu_pkg::FP_QBIT;
        if ((is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b))) return geu_pkg::FP_DNAN;
        if (is_inf(a) || is_zero(b)) return {a[31] ^ b[31], 8'hFF, 23'b0};
        if (is_inf(b)) return {a[31] ^ b[31], 31'b0};
        return real_to_sgl(sgl_to_real(a) / sgl_to_real(b));
    endfunction

    function automatic int dim_in_use(input logic [geu_pkg::SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (int'(s) > MAX_DIM) return MAX_DIM;
        return int'(s);
    endfunction

    // Reduce the shadow matrix to unit upper-triangular form
    task automatic reduce_matrix(input int n);
        logic [31:0] piv;
        logic [31:0] fac;
        for (int k = 0; k < n; k++) begin
            piv = shadow_mtx[k*n+k];
            for (int j = k + 1; j < n; j++)
                shadow_mtx[k*n+j] = fp_div(shadow_mtx[k*n+j], piv);
            shadow_mtx[k*n+k] = geu_pkg::FP_ONE;
            for (int i = k + 1; i < n; i++) begin
                fac = shadow_mtx[i*n+k];
                for (int j = k + 1; j < n; j++)
                    shadow_mtx[i*n+j] = fp_sub(shadow_mtx[i*n+j],
                                               fp_mul(fac, shadow_mtx[k*n+j]));
                shadow_mtx[i*n+k] = geu_pkg::FP_ZERO;
            end
        end
    endtask

    // Track configuration, predict on input transfers, compare output transfers
    always @(posedge i_clk) begin
        int        n;
        t_elem_exp got;
        t_elem_exp want;
        if (!i_rst_n) begin
            size_reg = geu_pkg::SIZE_RST;
            fill_cnt = 0;
            exp_elems.delete();
        end else begin
            if (i_cfg_wr_en) begin
                size_reg = i_cfg_wr_data;
                fill_cnt = 0;
            end
            if (i_valid && !i_in_stall) begin
                n = dim_in_use(size_reg);
                if (fill_cnt >= n * n)
                    fill_cnt = 0;
                shadow_mtx[fill_cnt & (MAX_DIM * MAX_DIM - 1)] = i_element_bits;
                fill_cnt++;
                if (fill_cnt >= n * n) begin
                    reduce_matrix(n);
                    fill_cnt = 0;
                    for (int e = 0; e < n * n; e++)
                        exp_elems.push_back('{shadow_mtx[e], e == n * n - 1});
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_result_bits, i_last_element};
                if (exp_elems.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h last %b",
                                              got.bits, got.last));
                end else begin
                    want = exp_elems.pop_front();
                    o_checked++;
                    if (got.bits !== want.bits)
                        report_mismatch($sformatf("result_bits %h, predicted %h",
                                                  got.bits, want.bits));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_element %b, predicted %b",
                                                  got.last, want.last));
                end
            end
        end
        o_pending = exp_elems.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top: drives matrices and size writes into the elimination unit and gives the verdict.
`timescale 1ns / 100ps

module tb;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [geu_pkg::SIZE_W-1:0] i_cfg_wr_data;
    logic                       i_valid;
    logic                       o_stall;
    logic [31:0]                i_element_bits;
    logic                       o_valid;
    logic                       i_stall;
    logic [31:0]                o_result_bits;
    logic                       o_last_element;

    int errors;
    int pending;
    int checked;
    int elems_sent;
    int matrices_done;
    int stall_left;
    bit quiet;

    gaussian_elimination_unit_upper u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_element_bits (i_element_bits),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_bits  (o_result_bits),
        .o_last_element (o_last_element)
    );

    geu_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .i_in_stall     (o_stall),
        .i_element_bits (i_element_bits),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_result_bits  (o_result_bits),
        .i_last_element (o_last_element),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Clock: 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Calm stretches with no idling, and none at all near the end
    function automatic bit calm();
        return quiet || (elems_sent % 100) < 20;
    endfunction

    // Stall the result channel in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm() && $urandom_range(0, 4) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Hand one element over; valid stays high on return
    task automatic put_element(input logic [31:0] v);
        if (!calm() && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_element_bits <= v;
        do @(posedge i_clk); while (o_stall);
        elems_sent++;
    endtask

    // Write the size once the unit has drained
    task automatic write_size(input logic [geu_pkg::SIZE_W-1:0] v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic int dim_of(input logic [geu_pkg::SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > 8) return 8;
        return int'(s);
    endfunction

    // Mostly moderate values, some raw patterns, specials and subnormals
    function automatic logic [31:0] rand_element();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return {1'($urandom), 8'(127 + $urandom_range(0, 12) - 6), 23'($urandom)};
        if (pick < 16)
            return $urandom;
        if (pick < 18)
            return {1'($urandom), 8'h00, 23'($urandom)};
        case ($urandom_range(0, 5))
            0: return geu_pkg::FP_ZERO;
            1: return 32'h8000_0000;
            2: return {1'($urandom), 8'hFF, 23'b0};
            3: return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
            4: return {1'($urandom), 31'h7F7F_FFFF};
            default: return geu_pkg::FP_ONE;
        endcase
    endfunction

    task automatic send_matrix(input int n);
        for (int e = 0; e < n * n; e++)
            put_element(rand_element());
        matrices_done++;
    endtask

    initial begin
        logic [geu_pkg::SIZE_W-1:0] sz;
        int                         n;
        int                         pick;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_valid        = 1'b0;
        i_element_bits = '0;
        elems_sent     = 0;
        matrices_done  = 0;
        quiet          = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Abandon a partial load at the reset size
        put_element(geu_pkg::FP_ONE);
        put_element(32'h4000_0000);
        put_element(32'hC040_0000);

        // Single element matrices with extreme and special values
        write_size(4'd1);
        put_element(geu_pkg::FP_ZERO);
        put_element(32'h8000_0000);
        put_element(32'h7F80_0000);
        put_element(32'hFFC0_0001);
        put_element(32'h7F80_0001);
        put_element(32'h0000_0001);
        put_element(32'hFFFF_FFFF);
        matrices_done += 7;

        // Size zero is taken as one
        write_size(4'd0);
        put_element(32'h7F7F_FFFF);
        matrices_done++;

        // Zero pivot, singular matrix, quiet NaN and infinity in the data
        write_size(4'd2);
        put_element(geu_pkg::FP_ZERO);
        put_element(geu_pkg::FP_ONE);
        put_element(32'h4000_0000);
        put_element(32'h4040_0000);
        put_element(32'h4000_0000);
        put_element(32'h4080_0000);
        put_element(geu_pkg::FP_ONE);
        put_element(32'h4000_0000);
        put_element(32'h4000_0000);
        put_element(32'h7FC0_0000);
        put_element(32'hFF80_0000);
        put_element(32'h0080_0000);
        matrices_done += 3;

        // Oversized write is clamped to the largest dimension
        write_size(4'd15);
        send_matrix(8);

        // Random matrices, mostly small
        while (elems_sent < 360) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                sz = 4'($urandom_range(8, 15));
            else if (pick < 3)
                sz = 4'($urandom_range(5, 7));
            else if (pick == 3)
                sz = 4'($urandom_range(0, 1));
            else
                sz = 4'($urandom_range(2, 4));
            n = dim_of(sz);
            if (elems_sent > 300)
                quiet = 1'b1;
            write_size(sz);
            if ($urandom_range(0, 9) == 0 && n > 1) begin
                for (int e = 0; e < $urandom_range(1, n * n - 1); e++)
                    put_element(rand_element());
                write_size(sz);
            end
            repeat ($urandom_range(1, 3))
                send_matrix(n);
        end

        // Drain
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (30) @(posedge i_clk);
        $display("Covered %0d matrices from %0d elements, %0d results checked.",
                 matrices_done, elems_sent, checked);
        $display("Sizes 0 to 15 incl. clamping, zero pivots, NaN/inf/subnormal data.");
        if (errors == 0) begin
            $display("gaussian_elimination_unit_upper regression: pass");
        end else begin
            $display("gaussian_elimination_unit_upper regression: fail");
        end
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("gaussian_elimination_unit_upper regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/geu_pkg.sv
design/geu_fpu.sv
design/geu_dp.sv
design/geu_ctrl.sv
design/gaussian_elimination_unit_upper.sv
verif/geu_checker.sv
verif/tb.sv
